>>> rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the min tracking stack
// Operation codes, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  // default capacity of the stack in entries
  localparam int DEFAULT_STACK_DEPTH = 256;

  // width of one stored value
  localparam int VALUE_W = 32;

  // operation field codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status codes reported with every result
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,   // ready for the next transaction
    ST_FILL = 1'b1    // waiting on memory read of the new top entry
  } state_t;

endpackage : mts_pkg

`default_nettype wire

>>> rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mts_ram

`default_nettype wire

>>> rtl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack: bounded stack of signed values with running minimum
// Each entry holds a value and the minimum of itself and all entries below.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_operation selects push or pop,
//   in_value is the value to push. Every input transaction yields exactly
//   one result transaction on out_valid/out_ready carrying the popped value,
//   the minimum of the contents, an empty flag and a status code.
//   Entries live in one memory with a registered read; the top entry is
//   cached in registers. A push, or a pop that empties the stack or hits an
//   empty stack, is completed from ST_IDLE alone, so its result appears the
//   cycle after acceptance. A pop that leaves entries behind passes through
//   ST_FILL: the new top entry is first read from memory and then loaded.
//   Pushes are accepted at one transaction per cycle while out_ready is
//   high; such pops hold off input until ST_FILL has loaded the new top.
//   A pop on empty reports status 1 and changes nothing; a push on full is
//   dropped with status 2. Reset empties the stack; the memory is not
//   cleared. While a result waits on out_ready, the next transaction is
//   accepted in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_operation,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [VALUE_W-1:0]       out_popped_value,
  output logic signed [VALUE_W-1:0]       out_current_min,
  output logic                            out_is_empty,
  output logic [1:0]                      out_status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = 2 * VALUE_W;

  // controller state and stack pointer
  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  // cached top entry
  logic signed [VALUE_W-1:0] top_val_r, top_val_nxt;
  logic signed [VALUE_W-1:0] top_min_r, top_min_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_pop_r, out_pop_nxt;
  logic signed [VALUE_W-1:0] out_min_r, out_min_nxt;
  logic                      out_empty_r, out_empty_nxt;
  status_t                   out_status_r, out_status_nxt;

  // memory interface
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  logic                      in_fire;
  logic                      is_full;
  logic                      is_zero;
  logic signed [VALUE_W-1:0] push_min;
  logic signed [VALUE_W-1:0] rd_val;
  logic signed [VALUE_W-1:0] rd_min;
  logic [CW-1:0]             count_m2;

  mts_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_pop_r;
  assign out_current_min  = out_min_r;
  assign out_is_empty     = out_empty_r;
  assign out_status       = out_status_r;

  // stack occupancy and running minimum for a push
  assign is_full  = (count_r == CW'(STACK_DEPTH));
  assign is_zero  = (count_r == '0);
  assign push_min = (!is_zero && (top_min_r < in_value)) ? top_min_r : in_value;
  assign rd_val   = ram_rdata[EW-1:VALUE_W];
  assign rd_min   = ram_rdata[VALUE_W-1:0];
  assign count_m2 = count_r - CW'(2);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_val_r    <= top_val_nxt;
    top_min_r    <= top_min_nxt;
    out_pop_r    <= out_pop_nxt;
    out_min_r    <= out_min_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    top_val_nxt    = top_val_r;
    top_min_nxt    = top_min_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pop_nxt    = out_pop_r;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = {in_value, push_min};
    ram_re         = 1'b0;
    ram_raddr      = count_m2[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_PUSH) begin
            if (is_full) begin
              // push on full: dropped, report unchanged stack
              out_valid_nxt  = 1'b1;
              out_pop_nxt    = '0;
              out_min_nxt    = is_zero ? '0 : top_min_r;
              out_empty_nxt  = is_zero;
              out_status_nxt = STATUS_PUSH_FULL;
            end else begin
              // push: write entry and update cached top
              ram_we         = 1'b1;
              top_val_nxt    = in_value;
              top_min_nxt    = push_min;
              count_nxt      = count_r + CW'(1);
              out_valid_nxt  = 1'b1;
              out_pop_nxt    = '0;
              out_min_nxt    = push_min;
              out_empty_nxt  = 1'b0;
              out_status_nxt = STATUS_OK;
            end
          end else begin
            if (is_zero) begin
              // pop on empty: ignored
              out_valid_nxt  = 1'b1;
              out_pop_nxt    = '0;
              out_min_nxt    = '0;
              out_empty_nxt  = 1'b1;
              out_status_nxt = STATUS_POP_EMPTY;
            end else if (count_r == CW'(1)) begin
              // pop of the last entry
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_pop_nxt    = top_val_r;
              out_min_nxt    = '0;
              out_empty_nxt  = 1'b1;
              out_status_nxt = STATUS_OK;
            end else begin
              // pop with entries left: fetch the new top entry
              ram_re    = 1'b1;
              count_nxt = count_r - CW'(1);
              state_nxt = ST_FILL;
            end
          end
        end
      end
      ST_FILL: begin
        // load new top and report the popped value
        top_val_nxt    = rd_val;
        top_min_nxt    = rd_min;
        out_valid_nxt  = 1'b1;
        out_pop_nxt    = top_val_r;
        out_min_nxt    = rd_min;
        out_empty_nxt  = 1'b0;
        out_status_nxt = STATUS_OK;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : min_tracking_stack

`default_nettype wire
